FILE: hw/rtl/interrupt_priority_controller_top_macros.svh
// Assertion shorthands for the interrupt priority controller.
// Both expect clk and arst_n in scope.
`ifndef INTERRUPT_PRIORITY_CONTROLLER_TOP_MACROS_SVH
`define INTERRUPT_PRIORITY_CONTROLLER_TOP_MACROS_SVH

// Check the consequent in the same cycle as the antecedent
`define IPC_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ipc assertion failed");

// Check the consequent in the cycle after the antecedent
`define IPC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ipc assertion failed");

`endif

FILE: hw/rtl/ipc_pkg.sv
package ipc_pkg;

	// Interrupt count and vector numbering
	localparam int NUM_IRQS       = 32;
	localparam int EXCEPTION_BASE = 16;
	localparam int IRQ_IDX_W      = (NUM_IRQS > 1) ? $clog2(NUM_IRQS) : 1;

	// Field widths
	localparam int DATA_W  = 32;
	localparam int ADDR_W  = 10;
	localparam int EXC_IN_W = 6;
	localparam int EXC_W   = 7;
	localparam int ACT_W   = 2;

	// Priority storage: four 2-bit levels per word, one byte each, level in bits 7:6
	localparam int PRIO_W        = 2;
	localparam int PRIO_LEVELS   = 4;
	localparam int PRIO_SHIFT    = 6;
	localparam int BYTE_W        = 8;
	localparam int PRIO_PER_WORD = 4;
	localparam int PRIO_SLOTS    = 32;
	localparam int PRIO_SLOT_W   = 5;
	localparam int PRIO_K_W      = 2;
	localparam int PRIO_WORD_W   = PRIO_SLOT_W - PRIO_K_W;

	// Stream payload widths
	localparam int S_TDATA_W = 88;
	localparam int M_TDATA_W = 40;

	// Bus access codes
	localparam logic [ACT_W-1:0] ACT_NONE  = 2'd0;
	localparam logic [ACT_W-1:0] ACT_READ  = 2'd1;
	localparam logic [ACT_W-1:0] ACT_WRITE = 2'd2;

	// Register map (byte offsets)
	localparam logic [ADDR_W-1:0] ADDR_SET_EN   = 10'h000;
	localparam logic [ADDR_W-1:0] ADDR_CLR_EN   = 10'h080;
	localparam logic [ADDR_W-1:0] ADDR_SET_PEND = 10'h100;
	localparam logic [ADDR_W-1:0] ADDR_CLR_PEND = 10'h180;
	localparam logic [ADDR_W-1:0] ADDR_PRIO     = 10'h300;

	// Winner of the priority compare
	typedef struct packed {
		logic                 found;
		logic [IRQ_IDX_W-1:0] index;
	} win_t;

endpackage

FILE: hw/rtl/ipc_arbiter.sv
module ipc_arbiter (
	input  logic [ipc_pkg::NUM_IRQS-1:0] cand,
	input  logic [ipc_pkg::PRIO_W-1:0]   levels [ipc_pkg::PRIO_SLOTS],
	output ipc_pkg::win_t                win
);
	import ipc_pkg::*;

	logic [NUM_IRQS-1:0] lvl_mask [PRIO_LEVELS];
	logic [NUM_IRQS-1:0] sel;

	// Split candidates by priority level
	always_comb begin
		for (int p = 0; p < PRIO_LEVELS; p++) begin
			for (int i = 0; i < NUM_IRQS; i++) begin
				lvl_mask[p][i] = cand[i] && (levels[i] == PRIO_W'(p));
			end
		end
	end

	// Take the lowest populated level, then its lowest index
	always_comb begin
		sel       = '0;
		win.found = |cand;
		win.index = '0;
		for (int p = PRIO_LEVELS - 1; p >= 0; p--) begin
			if (|lvl_mask[p]) begin
				sel = lvl_mask[p];
			end
		end
		for (int i = NUM_IRQS - 1; i >= 0; i--) begin
			if (sel[i]) begin
				win.index = IRQ_IDX_W'(i);
			end
		end
	end

endmodule

FILE: hw/rtl/interrupt_priority_controller_top.sv
// Interrupt priority controller for up to 32 request lines with enable,
// pending and 2-bit priority state. Each input word carries one optional bus
// access (read or write, selected by s_tuser) plus the request line levels
// and the CPU's active and returning exception numbers; each input word
// yields exactly one output word. The block takes one word per clock when
// m_tready does not hold back the result register. Each word passes from
// the input register, where the bus decode, pending update and 32-way
// priority compare settle, into the result register. All state is updated
// as the result register loads, so each word sees the effects of the one
// before it. Register map: 0x000
// set-enable, 0x080 clear-enable, 0x100 set-pending, 0x180 clear-pending,
// 0x300-0x31C priority (level in bits 7:6 of each byte); other offsets
// raise address_error. pending_exception is -1 when nothing is pending and
// 0 while power_on is low, which also freezes pending state.
`include "interrupt_priority_controller_top_macros.svh"

module interrupt_priority_controller_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// address[9:0], write_data[41:10], irq_lines[73:42], active_exception[79:74],
	// returning_exception[85:80], power_on[86], zero[87]
	input  logic [ipc_pkg::S_TDATA_W-1:0]  s_tdata,
	// action[1:0]
	input  logic [ipc_pkg::ACT_W-1:0]      s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// read_data[31:0], pending_exception[38:32], address_error[39]
	output logic [ipc_pkg::M_TDATA_W-1:0]  m_tdata
);
	import ipc_pkg::*;

	// Input register
	logic                valid_s1;
	logic [ACT_W-1:0]    action_s1;
	logic [ADDR_W-1:0]   address_s1;
	logic [DATA_W-1:0]   write_data_s1;
	logic [DATA_W-1:0]   irq_lines_s1;
	logic [EXC_IN_W-1:0] active_s1;
	logic [EXC_IN_W-1:0] returning_s1;
	logic                power_s1;

	// Result register
	logic                valid_s2;
	logic [DATA_W-1:0]   read_data_s2;
	logic [EXC_W-1:0]    pend_exc_s2;
	logic                addr_err_s2;

	// Controller state
	logic [NUM_IRQS-1:0] enable_q;
	logic [NUM_IRQS-1:0] pending_q;
	logic [NUM_IRQS-1:0] prev_lines_q;
	logic [EXC_W-1:0]    prev_active_q;
	logic [PRIO_W-1:0]   prio_q [PRIO_SLOTS];

	// Next state and result
	logic                  advance;
	logic                  is_rd, is_wr;
	logic                  hit_set_en, hit_clr_en, hit_set_pend, hit_clr_pend, hit_prio;
	logic                  addr_err;
	logic [PRIO_WORD_W-1:0] prio_n;
	logic [NUM_IRQS-1:0]   enable_nx;
	logic [NUM_IRQS-1:0]   pending_nx;
	logic [NUM_IRQS-1:0]   sw_set, sw_clr;
	logic [PRIO_W-1:0]     prio_nx [PRIO_SLOTS];
	logic [DATA_W-1:0]     rdata;
	logic [EXC_W-1:0]      pend_exc;
	logic [NUM_IRQS-1:0]   cand;
	win_t                  win;

	// Move a word from the input register into the result register
	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign m_tvalid = valid_s2;
	assign m_tdata  = {addr_err_s2, pend_exc_s2, read_data_s2};

	// Decode the bus access
	always_comb begin
		is_rd        = (action_s1 == ACT_READ);
		is_wr        = (action_s1 == ACT_WRITE);
		hit_set_en   = (address_s1[ADDR_W-1:2] == ADDR_SET_EN[ADDR_W-1:2]);
		hit_clr_en   = (address_s1[ADDR_W-1:2] == ADDR_CLR_EN[ADDR_W-1:2]);
		hit_set_pend = (address_s1[ADDR_W-1:2] == ADDR_SET_PEND[ADDR_W-1:2]);
		hit_clr_pend = (address_s1[ADDR_W-1:2] == ADDR_CLR_PEND[ADDR_W-1:2]);
		hit_prio     = (address_s1[ADDR_W-1:5] == ADDR_PRIO[ADDR_W-1:5]);
		prio_n       = address_s1[4:2];
		addr_err     = (is_rd || is_wr) &&
			!(hit_set_en || hit_clr_en || hit_set_pend || hit_clr_pend || hit_prio);
	end

	// Apply bus writes and form read data
	always_comb begin
		enable_nx = enable_q;
		sw_set    = '0;
		sw_clr    = '0;
		rdata     = '0;
		if (is_wr && hit_set_en) begin
			enable_nx = enable_q | write_data_s1[NUM_IRQS-1:0];
		end
		if (is_wr && hit_clr_en) begin
			enable_nx = enable_q & ~write_data_s1[NUM_IRQS-1:0];
		end
		if (is_wr && hit_set_pend && power_s1) begin
			sw_set = write_data_s1[NUM_IRQS-1:0];
		end
		if (is_wr && hit_clr_pend && power_s1) begin
			sw_clr = write_data_s1[NUM_IRQS-1:0];
		end
		if (is_rd && (hit_set_en || hit_clr_en)) begin
			rdata = DATA_W'(enable_q);
		end
		if (is_rd && (hit_set_pend || hit_clr_pend)) begin
			rdata = DATA_W'(pending_q);
		end
		if (is_rd && hit_prio) begin
			for (int k = 0; k < PRIO_PER_WORD; k++) begin
				rdata[BYTE_W*k + PRIO_SHIFT +: PRIO_W] = prio_q[{prio_n, PRIO_K_W'(k)}];
			end
		end
		for (int j = 0; j < PRIO_SLOTS; j++) begin
			if (is_wr && hit_prio && (PRIO_WORD_W'(j / PRIO_PER_WORD) == prio_n)) begin
				prio_nx[j] = write_data_s1[BYTE_W*(j % PRIO_PER_WORD) + PRIO_SHIFT +: PRIO_W];
			end else begin
				prio_nx[j] = prio_q[j];
			end
		end
	end

	// Update pending bits: set beats clear, handler entry clears
	always_comb begin
		pending_nx = pending_q;
		if (power_s1) begin
			for (int i = 0; i < NUM_IRQS; i++) begin
				if ((irq_lines_s1[i] && !prev_lines_q[i]) ||
					(irq_lines_s1[i] && ({1'b0, returning_s1} == EXC_W'(i + EXCEPTION_BASE))) ||
					sw_set[i]) begin
					pending_nx[i] = 1'b1;
				end else if ((!irq_lines_s1[i] && sw_clr[i]) ||
					(({1'b0, active_s1} == EXC_W'(i + EXCEPTION_BASE)) &&
					({1'b0, active_s1} != prev_active_q))) begin
					pending_nx[i] = 1'b0;
				end
			end
		end
		cand = pending_nx & enable_nx;
	end

	ipc_arbiter u_arbiter (
		.cand   (cand),
		.levels (prio_nx),
		.win    (win)
	);

	// Form the reported exception number
	always_comb begin
		if (!power_s1) begin
			pend_exc = '0;
		end else if (win.found) begin
			pend_exc = EXC_W'(win.index) + EXC_W'(EXCEPTION_BASE);
		end else begin
			pend_exc = '1;
		end
	end

	// Hold handshake flags and controller state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1      <= 1'b0;
			valid_s2      <= 1'b0;
			enable_q      <= '0;
			pending_q     <= '0;
			prev_lines_q  <= '0;
			prev_active_q <= '1;
			for (int j = 0; j < PRIO_SLOTS; j++) begin
				prio_q[j] <= '0;
			end
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (m_tready) begin
				valid_s2 <= 1'b0;
			end
			if (advance) begin
				enable_q  <= enable_nx;
				pending_q <= pending_nx;
				for (int j = 0; j < PRIO_SLOTS; j++) begin
					prio_q[j] <= prio_nx[j];
				end
				if (power_s1) begin
					prev_lines_q  <= irq_lines_s1[NUM_IRQS-1:0];
					prev_active_q <= {1'b0, active_s1};
				end
			end
		end
	end

	// Capture input words and results
	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			action_s1     <= s_tuser;
			address_s1    <= s_tdata[9:0];
			write_data_s1 <= s_tdata[41:10];
			irq_lines_s1  <= s_tdata[73:42];
			active_s1     <= s_tdata[79:74];
			returning_s1  <= s_tdata[85:80];
			power_s1      <= s_tdata[86];
		end
		if (advance) begin
			read_data_s2 <= rdata;
			pend_exc_s2  <= pend_exc;
			addr_err_s2  <= addr_err;
		end
	end

	// The winner must be an enabled pending line
	`IPC_ASSERT_NOW(a_win_is_cand, valid_s1 && win.found, cand[win.index])
	// Unmapped accesses read back zero
	`IPC_ASSERT_NOW(a_err_reads_zero, valid_s1 && addr_err, rdata == '0)
	// Powered off: pending state frozen and zero reported
	`IPC_ASSERT_NEXT(a_power_off_freeze, advance && !power_s1, (pending_q == $past(pending_q)) && (pend_exc_s2 == '0))
	// State only moves when a word is processed
	`IPC_ASSERT_NEXT(a_state_idle_hold, !advance, $stable(enable_q) && $stable(pending_q))

endmodule
